[design/cmvm_pkg.sv]
`timescale 1ns / 1ps

package cmvm_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int DIM_LIMIT   = 16;

  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int ELEM_W   = 32;
  localparam int PROD_W   = 32;
  localparam int TERM_W   = 33;
  localparam int ACC_W    = 38;
  localparam int MUL_W    = 54;
  localparam int SUM_W    = 56;
  localparam int RND_BIT  = 26;
  localparam int SHIFT    = 27;
  localparam int Q_W      = SUM_W - SHIFT;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_IM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_RE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_IM    = 3'd6;

  localparam logic [1:0] MODE_PLAIN = 2'd0;

  localparam logic signed [15:0] ALPHA_RE_RST = 16'sd4096;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_LOAD_A = 2'd2,
    OP_START  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_ISSUE,
    ST_DRAIN,
    ST_FMUL,
    ST_FSUM,
    ST_FOUT
  } state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
  } in_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic               last_flag;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [1:0]         trans_mode;
    logic [CNT_W-1:0]   rows_m;
    logic [CNT_W-1:0]   cols_n;
    logic signed [15:0] alpha_re;
    logic signed [15:0] alpha_im;
    logic signed [15:0] beta_re;
    logic signed [15:0] beta_im;
  } cfg_t;

  typedef struct packed {
    logic             ld_x;
    logic             ld_y;
    logic             ld_a;
    logic             acc_clr;
    logic             y_rd;
    logic             issue;
    logic             fin_mul;
    logic             fin_sum;
    logic             fin_out;
    logic             last;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

[design/cmvm_cfg.sv]
`timescale 1ns / 1ps

module cmvm_cfg
  import cmvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRANS_MODE: cfg_nxt.trans_mode = cfg_wdata[1:0];
        CFG_ROWS_M:     cfg_nxt.rows_m     = cfg_wdata[CNT_W-1:0];
        CFG_COLS_N:     cfg_nxt.cols_n     = cfg_wdata[CNT_W-1:0];
        CFG_ALPHA_RE:   cfg_nxt.alpha_re   = cfg_wdata;
        CFG_ALPHA_IM:   cfg_nxt.alpha_im   = cfg_wdata;
        CFG_BETA_RE:    cfg_nxt.beta_re    = cfg_wdata;
        CFG_BETA_IM:    cfg_nxt.beta_im    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trans_mode <= MODE_PLAIN;
      cfg_r.rows_m     <= '0;
      cfg_r.cols_n     <= '0;
      cfg_r.alpha_re   <= ALPHA_RE_RST;
      cfg_r.alpha_im   <= '0;
      cfg_r.beta_re    <= '0;
      cfg_r.beta_im    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/cmvm_ctrl.sv]
`timescale 1ns / 1ps

module cmvm_ctrl
  import cmvm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  opcode_t in_opcode,
  input  cfg_t    cfg,
  input  stat_t   stat,
  output cmd_t    cmd
);

  localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(DIM_CAP);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] nrows_r, nrows_nxt;
  logic [CNT_W-1:0] ncols_r, ncols_nxt;
  logic             drain_r, drain_nxt;
  logic [CNT_W-1:0] m_cap, n_cap;
  logic             last_row;

  assign m_cap    = (cfg.rows_m > CAP) ? CAP : cfg.rows_m;
  assign n_cap    = (cfg.cols_n > CAP) ? CAP : cfg.cols_n;
  assign last_row = (i_r == nrows_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      nrows_r <= '0;
      ncols_r <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      nrows_r <= nrows_nxt;
      ncols_r <= ncols_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    nrows_nxt = nrows_r;
    ncols_nxt = ncols_r;
    drain_nxt = drain_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.row   = i_r;
    cmd.col   = j_r;
    cmd.last  = last_row;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_opcode)
            OP_LOAD_X: cmd.ld_x = 1'b1;
            OP_LOAD_Y: cmd.ld_y = 1'b1;
            OP_LOAD_A: cmd.ld_a = 1'b1;
            OP_START: begin
              nrows_nxt = (cfg.trans_mode == MODE_PLAIN) ? m_cap : n_cap;
              ncols_nxt = (cfg.trans_mode == MODE_PLAIN) ? n_cap : m_cap;
              i_nxt     = '0;
              if (nrows_nxt != '0) begin
                state_nxt = ST_ROW;
              end
            end
          endcase
        end
      end
      ST_ROW: begin
        cmd.acc_clr = 1'b1;
        cmd.y_rd    = 1'b1;
        j_nxt       = '0;
        state_nxt   = (ncols_r == '0) ? ST_FMUL : ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        j_nxt     = j_r + CNT_W'(1);
        if (j_r == ncols_r - CNT_W'(1)) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_FMUL;
        end
      end
      ST_FMUL: begin
        cmd.fin_mul = 1'b1;
        state_nxt   = ST_FSUM;
      end
      ST_FSUM: begin
        cmd.fin_sum = 1'b1;
        state_nxt   = ST_FOUT;
      end
      ST_FOUT: begin
        if (stat.out_free) begin
          cmd.fin_out = 1'b1;
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = ST_ROW;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[design/cmvm_datapath.sv]
`timescale 1ns / 1ps

module cmvm_datapath
  import cmvm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cfg_t cfg,
  input  cmd_t cmd,
  output stat_t stat,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << RND_BIT;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

  logic [ELEM_W-1:0] mem_a [DEPTH];
  logic [ELEM_W-1:0] mem_x [MAX_DIM];
  logic [ELEM_W-1:0] mem_y [MAX_DIM];

  logic [ELEM_W-1:0] a_rd_r, x_rd_r, y_rd_r;
  logic              s1_valid_r, s2_valid_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [MUL_W-1:0]  m_rr_r, m_ii_r, m_ri_r, m_ir_r;
  logic signed [PROD_W-1:0] b_rr_r, b_ii_r, b_ri_r, b_ir_r;
  logic signed [SUM_W-1:0]  t_re_r, t_im_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              row_ok, col_ok, conj;
  logic [ELEM_W-1:0] ld_word;
  logic [AW-1:0]     a_wa, a_ra;
  logic signed [15:0] a_re, a_im, x_re, x_im, y_re, y_im;
  logic signed [TERM_W-1:0] term_re, term_im;
  logic signed [SUM_W-1:0]  v_re, v_im;
  logic signed [Q_W-1:0]    q_re, q_im;
  logic signed [15:0]       o_re, o_im;
  logic                     sat_re, sat_im;

  assign row_ok  = {3'b000, in_data.row_index} < 7'(MAX_DIM);
  assign col_ok  = {3'b000, in_data.col_index} < 7'(MAX_DIM);
  assign ld_word = {in_data.value_im, in_data.value_re};
  assign conj    = cfg.trans_mode[1];
  assign a_wa    = AW'(in_data.row_index) * AW'(MAX_DIM) + AW'(in_data.col_index);
  assign a_ra    = (cfg.trans_mode == MODE_PLAIN)
                 ? AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.col)
                 : AW'(cmd.col) * AW'(MAX_DIM) + AW'(cmd.row);

  always_ff @(posedge clk) begin
    if (cmd.ld_a && row_ok && col_ok) begin
      mem_a[a_wa] <= ld_word;
    end
    if (cmd.issue) begin
      a_rd_r <= mem_a[a_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_x && row_ok) begin
      mem_x[IW'(in_data.row_index)] <= ld_word;
    end
    if (cmd.issue) begin
      x_rd_r <= mem_x[IW'(cmd.col)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_out) begin
      mem_y[IW'(cmd.row)] <= {o_im, o_re};
    end else if (cmd.ld_y && row_ok) begin
      mem_y[IW'(in_data.row_index)] <= ld_word;
    end
    if (cmd.y_rd) begin
      y_rd_r <= mem_y[IW'(cmd.row)];
    end
  end

  assign a_re = a_rd_r[15:0];
  assign a_im = a_rd_r[31:16];
  assign x_re = x_rd_r[15:0];
  assign x_im = x_rd_r[31:16];
  assign y_re = y_rd_r[15:0];
  assign y_im = y_rd_r[31:16];

  // complex multiply, conjugate folded into the combine step
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      p_rr_r <= a_re * x_re;
      p_ii_r <= a_im * x_im;
      p_ri_r <= a_re * x_im;
      p_ir_r <= a_im * x_re;
    end
  end

  assign term_re = conj ? TERM_W'(p_rr_r) + TERM_W'(p_ii_r)
                        : TERM_W'(p_rr_r) - TERM_W'(p_ii_r);
  assign term_im = conj ? TERM_W'(p_ri_r) - TERM_W'(p_ir_r)
                        : TERM_W'(p_ri_r) + TERM_W'(p_ir_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (s2_valid_r) begin
      acc_re_r <= acc_re_r + ACC_W'(term_re);
      acc_im_r <= acc_im_r + ACC_W'(term_im);
    end
  end

  // alpha and beta scaling
  always_ff @(posedge clk) begin
    if (cmd.fin_mul) begin
      m_rr_r <= cfg.alpha_re * acc_re_r;
      m_ii_r <= cfg.alpha_im * acc_im_r;
      m_ri_r <= cfg.alpha_re * acc_im_r;
      m_ir_r <= cfg.alpha_im * acc_re_r;
      b_rr_r <= cfg.beta_re * y_re;
      b_ii_r <= cfg.beta_im * y_im;
      b_ri_r <= cfg.beta_re * y_im;
      b_ir_r <= cfg.beta_im * y_re;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_sum) begin
      t_re_r <= SUM_W'(m_rr_r) - SUM_W'(m_ii_r) + (SUM_W'(b_rr_r - b_ii_r) <<< 15);
      t_im_r <= SUM_W'(m_ri_r) + SUM_W'(m_ir_r) + (SUM_W'(b_ri_r + b_ir_r) <<< 15);
    end
  end

  // round half up, then clip to q1.15
  assign v_re   = t_re_r + RND;
  assign v_im   = t_im_r + RND;
  assign q_re   = v_re[SUM_W-1:SHIFT];
  assign q_im   = v_im[SUM_W-1:SHIFT];
  assign sat_re = (q_re > Q_MAX) || (q_re < Q_MIN);
  assign sat_im = (q_im > Q_MAX) || (q_im < Q_MIN);
  assign o_re   = (q_re > Q_MAX) ? 16'sh7fff : (q_re < Q_MIN) ? 16'sh8000 : q_re[15:0];
  assign o_im   = (q_im > Q_MAX) ? 16'sh7fff : (q_im < Q_MIN) ? 16'sh8000 : q_im[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_out) begin
      out_r.out_index <= cmd.row[3:0];
      out_r.out_re    <= o_re;
      out_r.out_im    <= o_im;
      out_r.last_flag <= cmd.last;
      out_r.saturated <= sat_re || sat_im;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

[design/complex_matrix_vector_multiply_top.sv]
`timescale 1ns / 1ps

// complex y = alpha * op(A) * x + beta * y in q1.15, alpha and beta q4.12
// input channel (in_valid / in_ready / in_data): each request loads one element of
// x, y or A, or starts a computation; loads are accepted back to back while the
// block is idle
// a start walks the rows of op(A); each row takes a row setup step, one complex
// MAC per column through the A and x memory read ports, a pipeline drain (MAC and
// drain are skipped when the inner length is zero), then scale, sum and round; no
// request is accepted until the last row has been handed over
// output channel (out_valid / out_ready / out_data): one result per row, in row
// order, last_flag on the final one; each result is also written back into y
// the output register frees as the receiver takes a result; a stalled receiver
// holds the block in its final row step until that register is free
// configuration (cfg_we / cfg_index / cfg_wdata) must be written only while idle;
// the block itself does not enforce this; reset restores the default registers
// (alpha = 1); A, x and y hold no defined contents until they are loaded

module complex_matrix_vector_multiply_top
  import cmvm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  cmvm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cmvm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .cfg       (cfg),
    .stat      (stat),
    .cmd       (cmd)
  );

  cmvm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue || cmd.fin_mul || cmd.fin_sum || cmd.fin_out) |-> !in_ready)
    else $error("request accepted during computation");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc_clr, cmd.issue, cmd.fin_mul, cmd.fin_sum, cmd.fin_out}))
    else $error("overlapping datapath commands");

  a_load_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_x || cmd.ld_y || cmd.ld_a) |-> (in_valid && in_ready))
    else $error("store write without accepted request");

endmodule
